### rtl/core/ssb_pkg.sv
// Shared types and constants for the sprite stamp blitter.
// No dependencies; imported by every module of the block.
package ssb_pkg;

  // Largest sprite dimension the counters are sized for.
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned ColW     = $clog2(MaxDim);
  localparam int unsigned RowW     = ColW + 1;
  localparam int unsigned DimW     = 13;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned KeyW     = 3 * ChanW;
  localparam int unsigned AddrW    = 26;
  localparam int unsigned PixShift = 2;  // four bytes per canvas pixel
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = KeyW;

  // Signed canvas position widths, room for origin plus counter.
  localparam int unsigned CxW = ((DimW > ColW) ? DimW : ColW) + 2;
  localparam int unsigned CyW = ((DimW > RowW) ? DimW : RowW) + 2;
  // Compare width for the column wrap test.
  localparam int unsigned WrapW = ((ColW + 1) > DimW) ? (ColW + 1) : DimW;

  localparam logic [RowW-1:0]  RowMax   = RowW'(2 * MaxDim - 1);
  localparam logic [ChanW-1:0] ChanFull = '1;
  localparam logic [ChanW-1:0] DarkLim  = ChanW'(128);

  localparam logic [DimW-1:0] CanvasWidthRst  = DimW'(640);
  localparam logic [DimW-1:0] CanvasHeightRst = DimW'(480);
  localparam logic [DimW-1:0] SourceWidthRst  = DimW'(1);
  localparam logic [KeyW-1:0] KeyColorRst     = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegCanvasWidth  = 3'd0,
    RegCanvasHeight = 3'd1,
    RegOriginX      = 3'd2,
    RegOriginY      = 3'd3,
    RegSourceWidth  = 3'd4,
    RegBlendMode    = 3'd5,
    RegMaskHigh     = 3'd6,
    RegKeyColor     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [DimW-1:0]        canvas_width;
    logic [DimW-1:0]        canvas_height;
    logic signed [DimW-1:0] origin_x;
    logic signed [DimW-1:0] origin_y;
    logic [DimW-1:0]        source_width;
    logic                   aura_mode;
    logic                   mask_inside_high;
    logic [KeyW-1:0]        key_color;
  } cfg_t;

  // Located and classified pixel, handed from the front stage to the address stage.
  typedef struct packed {
    logic             in_canvas;
    logic             opaque;
    logic [DimW-1:0]  pos_x;
    logic [DimW-1:0]  pos_y;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_t;

endpackage

### rtl/core/ssb_cfg_regs.sv
// Configuration register file of the sprite stamp blitter.
// Depends on ssb_pkg for the register index codes and the cfg_t bundle.
module ssb_cfg_regs import ssb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegCanvasWidth:  cfg_d.canvas_width     = cfg_data_i[DimW-1:0];
        RegCanvasHeight: cfg_d.canvas_height    = cfg_data_i[DimW-1:0];
        RegOriginX:      cfg_d.origin_x         = $signed(cfg_data_i[DimW-1:0]);
        RegOriginY:      cfg_d.origin_y         = $signed(cfg_data_i[DimW-1:0]);
        RegSourceWidth:  cfg_d.source_width     = cfg_data_i[DimW-1:0];
        RegBlendMode:    cfg_d.aura_mode        = cfg_data_i[0];
        RegMaskHigh:     cfg_d.mask_inside_high = cfg_data_i[0];
        RegKeyColor:     cfg_d.key_color        = cfg_data_i[KeyW-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width     <= CanvasWidthRst;
      cfg_q.canvas_height    <= CanvasHeightRst;
      cfg_q.origin_x         <= '0;
      cfg_q.origin_y         <= '0;
      cfg_q.source_width     <= SourceWidthRst;
      cfg_q.aura_mode        <= 1'b0;
      cfg_q.mask_inside_high <= 1'b1;
      cfg_q.key_color        <= KeyColorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/ssb_front.sv
// Front stage: sprite column/row counters, origin offset, canvas clip and
// opacity decision and aura colour override, registered into a pix_t. Depends on ssb_pkg.
module ssb_front import ssb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             frame_start_i,
  input  logic [ChanW-1:0] src_red_i,
  input  logic [ChanW-1:0] src_green_i,
  input  logic [ChanW-1:0] src_blue_i,
  input  logic             mask_covers_i,
  input  logic             mask_bit_i,
  output logic             pix_valid_o,
  input  logic             pix_ready_i,
  output pix_t             pix_o
);

  logic [ColW-1:0]  col_q, col_d, col_cur;
  logic [RowW-1:0]  row_q, row_d, row_cur;
  logic [ColW:0]    col_next;
  logic             wrap;
  logic             accept;
  logic signed [CxW-1:0] cx, cw_ext;
  logic signed [CyW-1:0] cy, ch_ext;
  logic             in_canvas;
  logic             opaque;
  logic             dark;
  logic             pix_valid_q;
  pix_t             pix_q, pix_d;

  assign in_ready_o = !pix_valid_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A frame start restarts the sprite at pixel zero before it is used.
  assign col_cur  = frame_start_i ? '0 : col_q;
  assign row_cur  = frame_start_i ? '0 : row_q;
  assign col_next = {1'b0, col_cur} + (ColW + 1)'(1);
  assign wrap     = (WrapW'(col_next) >= WrapW'(cfg_i.source_width)) ||
                    (col_next >= (ColW + 1)'(MaxDim));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (wrap) begin
        col_d = '0;
        row_d = (row_cur < RowMax) ? row_cur + RowW'(1) : row_cur;
      end else begin
        col_d = col_next[ColW-1:0];
        row_d = row_cur;
      end
    end
  end

  assign cx = $signed({{(CxW - DimW){cfg_i.origin_x[DimW-1]}}, cfg_i.origin_x}) +
              $signed({{(CxW - ColW){1'b0}}, col_cur});
  assign cy = $signed({{(CyW - DimW){cfg_i.origin_y[DimW-1]}}, cfg_i.origin_y}) +
              $signed({{(CyW - RowW){1'b0}}, row_cur});
  assign cw_ext = $signed({{(CxW - DimW){1'b0}}, cfg_i.canvas_width});
  assign ch_ext = $signed({{(CyW - DimW){1'b0}}, cfg_i.canvas_height});

  assign in_canvas = !cx[CxW-1] && (cx < cw_ext) && !cy[CyW-1] && (cy < ch_ext);

  assign dark = (src_red_i < DarkLim) && (src_green_i < DarkLim) && (src_blue_i < DarkLim);

  always_comb begin
    if (cfg_i.aura_mode) begin
      opaque = dark;
    end else if (mask_covers_i) begin
      opaque = cfg_i.mask_inside_high ? mask_bit_i : !mask_bit_i;
    end else begin
      opaque = {src_red_i, src_green_i, src_blue_i} != cfg_i.key_color;
    end
  end

  always_comb begin
    pix_d.in_canvas = in_canvas;
    pix_d.opaque    = opaque;
    pix_d.pos_x     = cx[DimW-1:0];
    pix_d.pos_y     = cy[DimW-1:0];
    pix_d.red       = cfg_i.aura_mode ? ChanFull : src_red_i;
    pix_d.green     = cfg_i.aura_mode ? ChanFull : src_green_i;
    pix_d.blue      = cfg_i.aura_mode ? ChanFull : src_blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_ready_o) begin
        pix_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_d;
    end
  end

  assign pix_valid_o = pix_valid_q;
  assign pix_o       = pix_q;

`ifndef SYNTHESIS
  // row only climbs within a sprite
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !frame_start_i) |=> (row_q >= $past(row_q)))
    else $error("ssb_front: row counter went backwards");
  // a frame start leaves the row at zero or one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_start_i) |=> (row_q <= RowW'(1)))
    else $error("ssb_front: frame start did not restart rows");
`endif

endmodule

### rtl/core/ssb_back.sv
// Address stage: row * stride + column, scaled to bytes, and the result
// register with the write enable. Depends on ssb_pkg.
module ssb_back import ssb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             pix_valid_i,
  output logic             pix_ready_o,
  input  pix_t             pix_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             write_enable_o,
  output logic [AddrW-1:0] byte_address_o,
  output logic [ChanW-1:0] out_red_o,
  output logic [ChanW-1:0] out_green_o,
  output logic [ChanW-1:0] out_blue_o
);

  logic [2*DimW-1:0] prod;
  logic [2*DimW:0]   lin;
  logic              take;
  logic              out_valid_q;
  logic              we_q, we_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [ChanW-1:0]  red_q, green_q, blue_q;

  assign pix_ready_o = !out_valid_q || out_ready_i;
  assign take        = pix_valid_i && pix_ready_o;

  assign prod = (2 * DimW)'(pix_i.pos_y) * (2 * DimW)'(cfg_i.canvas_width);
  assign lin  = {1'b0, prod} + (2 * DimW + 1)'(pix_i.pos_x);

  // Clipped pixels report a zero address.
  assign addr_d = pix_i.in_canvas ? {lin[AddrW-PixShift-1:0], {PixShift{1'b0}}} : '0;
  assign we_d   = pix_i.in_canvas && pix_i.opaque;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      we_q    <= we_d;
      addr_q  <= addr_d;
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign byte_address_o = addr_q;
  assign out_red_o      = red_q;
  assign out_green_o    = green_q;
  assign out_blue_o     = blue_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !pix_i.in_canvas) |=> (out_valid_o && !write_enable_o && byte_address_o == '0))
    else $error("ssb_back: clipped pixel produced a write or address");
`endif

endmodule

### rtl/core/sprite_stamp_blitter_top.sv
// Sprite stamp blitter top level: config registers, front and address stages.
// Depends on ssb_pkg, ssb_cfg_regs, ssb_front and ssb_back.
//
// One canvas write request comes out for every source pixel request taken in, in order.
// Throughput is one pixel per clock while the output is not stalled; a result
// passes the front register, then the address register after the
// row-times-stride multiply. Both stages hold their request under
// back-pressure and a new pixel is taken whenever the front register is
// free or moving on.
// Counters restart on frame_start; the column wraps at source_width (zero acts
// as one, capped at MaxDim) and the row saturates. Clipped pixels give
// write_enable 0 and a zero address. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i and must only change while no pixel is in flight.
module sprite_stamp_blitter_top import ssb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                frame_start_i,
  input  logic [ChanW-1:0]    src_red_i,
  input  logic [ChanW-1:0]    src_green_i,
  input  logic [ChanW-1:0]    src_blue_i,
  input  logic                mask_covers_i,
  input  logic                mask_bit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                write_enable_o,
  output logic [AddrW-1:0]    byte_address_o,
  output logic [ChanW-1:0]    out_red_o,
  output logic [ChanW-1:0]    out_green_o,
  output logic [ChanW-1:0]    out_blue_o,
  output logic [ChanW-1:0]    out_alpha_o
);

  cfg_t cfg;
  pix_t pix;
  logic pix_valid;
  logic pix_ready;

  ssb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ssb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_start_i (frame_start_i),
    .src_red_i     (src_red_i),
    .src_green_i   (src_green_i),
    .src_blue_i    (src_blue_i),
    .mask_covers_i (mask_covers_i),
    .mask_bit_i    (mask_bit_i),
    .pix_valid_o   (pix_valid),
    .pix_ready_i   (pix_ready),
    .pix_o         (pix)
  );

  ssb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .pix_valid_i    (pix_valid),
    .pix_ready_o    (pix_ready),
    .pix_i          (pix),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .byte_address_o (byte_address_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o)
  );

  assign out_alpha_o = ChanFull;

`ifndef SYNTHESIS
  // both stages full and stalled: nothing more may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("sprite_stamp_blitter_top: pipeline overrun");
  // an accepted pixel is held in the front register next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> pix_valid)
    else $error("sprite_stamp_blitter_top: accepted pixel lost");
  // a front request that cannot move stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid && !pix_ready) |=> (pix_valid && $stable(pix)))
    else $error("sprite_stamp_blitter_top: stalled pixel changed");
`endif

endmodule

### tb/sv/sprite_stamp_blitter_top_test.sv
// Self-checking testbench for sprite_stamp_blitter_top: pixel stream in, canvas writes out.
// Depends on ssb_pkg for widths, reset values and register indexes; needs only the RTL.
// Expected writes come from a local blitter predictor; both handshakes stall at random.
module sprite_stamp_blitter_top_test;
  import ssb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhasePixels = 100;
  localparam int unsigned TallPixels  = 64;

  typedef struct packed {
    logic             frame_start;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             mask_covers;
    logic             mask_bit;
  } sprite_pixel_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] byte_address;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } canvas_write_t;

  typedef enum logic {RowReg, RowPix} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    cfg_reg_e           idx;
    logic [CfgDataW-1:0] data;
    sprite_pixel_t      px;
    bit                 typed;
    canvas_write_t      want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                frame_start_i  = 1'b0;
  logic [ChanW-1:0]    src_red_i      = '0;
  logic [ChanW-1:0]    src_green_i    = '0;
  logic [ChanW-1:0]    src_blue_i     = '0;
  logic                mask_covers_i  = 1'b0;
  logic                mask_bit_i     = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                write_enable_o;
  logic [AddrW-1:0]    byte_address_o;
  logic [ChanW-1:0]    out_red_o;
  logic [ChanW-1:0]    out_green_o;
  logic [ChanW-1:0]    out_blue_o;
  logic [ChanW-1:0]    out_alpha_o;

  sprite_stamp_blitter_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_start_i  (frame_start_i),
    .src_red_i      (src_red_i),
    .src_green_i    (src_green_i),
    .src_blue_i     (src_blue_i),
    .mask_covers_i  (mask_covers_i),
    .mask_bit_i     (mask_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .byte_address_o (byte_address_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_alpha_o    (out_alpha_o)
  );

  // Predictor state: register shadow plus sprite position counters.
  cfg_t             shadow;
  logic [ColW-1:0]  col_pos;
  logic [RowW-1:0]  row_pos;

  canvas_write_t write_q[$];
  stim_row_t     plan[$];

  int unsigned mismatches     = 0;
  int unsigned pixels_sent    = 0;
  int unsigned reg_writes     = 0;
  int unsigned writes_checked = 0;
  int unsigned writes_enabled = 0;
  int unsigned idle_cycles    = 0;
  int unsigned snk_hold       = 0;
  bit          snk_steady     = 1'b0;
  bit          src_steady     = 1'b0;
  canvas_write_t got_w;
  canvas_write_t want_w;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("write %0d %s got 0x%0h want 0x%0h",
                              writes_checked, name, got, want));
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Locates the pixel, clips it, decides opacity, colours and byte address, and advances the counters.
  function automatic canvas_write_t predict_write(sprite_pixel_t px);
    canvas_write_t w;
    int            ox, oy, cx, cy, nxt;
    bit            in_canvas, opaque;
    longint        lin;
    if (px.frame_start) begin
      col_pos = '0;
      row_pos = '0;
    end
    ox = {{(32 - DimW){shadow.origin_x[DimW-1]}}, shadow.origin_x};
    oy = {{(32 - DimW){shadow.origin_y[DimW-1]}}, shadow.origin_y};
    cx = ox + int'(col_pos);
    cy = oy + int'(row_pos);
    in_canvas = cx >= 0 && cx < int'(shadow.canvas_width) &&
                cy >= 0 && cy < int'(shadow.canvas_height);
    if (shadow.aura_mode) begin
      opaque = px.red < DarkLim && px.green < DarkLim && px.blue < DarkLim;
      w.red   = ChanFull;
      w.green = ChanFull;
      w.blue  = ChanFull;
    end else begin
      if (px.mask_covers) begin
        opaque = shadow.mask_inside_high ? px.mask_bit : !px.mask_bit;
      end else begin
        opaque = {px.red, px.green, px.blue} != shadow.key_color;
      end
      w.red   = px.red;
      w.green = px.green;
      w.blue  = px.blue;
    end
    w.byte_address = '0;
    if (in_canvas) begin
      lin = (longint'(cy) * longint'(shadow.canvas_width) + longint'(cx)) * 4;
      w.byte_address = lin[AddrW-1:0];
    end
    w.write_enable = in_canvas && opaque;
    w.alpha = ChanFull;
    nxt = int'(col_pos) + 1;
    if (nxt >= int'(shadow.source_width) || nxt >= int'(MaxDim)) begin
      col_pos = '0;
      if (row_pos != RowMax) row_pos++;
    end else begin
      col_pos = ColW'(nxt);
    end
    return w;
  endfunction

  function automatic sprite_pixel_t pix(bit fs, logic [KeyW-1:0] rgb, bit cov, bit mb);
    return '{fs, rgb[23:16], rgb[15:8], rgb[7:0], cov, mb};
  endfunction

  function automatic canvas_write_t wr(bit we, int unsigned addr, logic [KeyW-1:0] rgb);
    return '{we, AddrW'(addr), rgb[23:16], rgb[15:8], rgb[7:0], ChanFull};
  endfunction

  function automatic void add_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    plan.push_back('{RowReg, idx, data, '0, 1'b0, '0});
  endfunction

  function automatic void add_pix(sprite_pixel_t px, bit typed = 1'b0,
                                  canvas_write_t want = '0);
    plan.push_back('{RowPix, RegCanvasWidth, '0, px, typed, want});
  endfunction

  function automatic logic [DimW-1:0] rand_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DimW'(MaxDim);
      2:       return '1;
      3:       return DimW'(1);
      default: return DimW'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [DimW-1:0] rand_origin();
    case ($urandom_range(0, 11))
      0:       return {1'b1, {(DimW - 1){1'b0}}};
      1:       return {1'b0, {(DimW - 1){1'b1}}};
      2:       return DimW'($urandom);
      default: return DimW'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  function automatic sprite_pixel_t rand_pixel(bit fs);
    logic [KeyW-1:0] rgb;
    case ($urandom_range(0, 4))
      0: rgb = shadow.key_color;
      1: rgb = {1'b0, 7'($urandom), 1'b0, 7'($urandom), 1'b0, 7'($urandom)};
      // straddle the dark threshold channel by channel
      2: rgb = {$urandom_range(0, 1) ? 8'd127 : 8'd128,
                $urandom_range(0, 1) ? 8'd127 : 8'd128,
                $urandom_range(0, 1) ? 8'd127 : 8'd128};
      default: rgb = KeyW'($urandom);
    endcase
    return pix(fs, rgb, 1'($urandom), 1'($urandom));
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      RegCanvasWidth:  shadow.canvas_width     = data[DimW-1:0];
      RegCanvasHeight: shadow.canvas_height    = data[DimW-1:0];
      RegOriginX:      shadow.origin_x         = data[DimW-1:0];
      RegOriginY:      shadow.origin_y         = data[DimW-1:0];
      RegSourceWidth:  shadow.source_width     = data[DimW-1:0];
      RegBlendMode:    shadow.aura_mode        = data[0];
      RegMaskHigh:     shadow.mask_inside_high = data[0];
      RegKeyColor:     shadow.key_color        = data[KeyW-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(RegCanvasWidth,  CfgDataW'(c.canvas_width));
    write_reg(RegCanvasHeight, CfgDataW'(c.canvas_height));
    write_reg(RegOriginX,      CfgDataW'(c.origin_x));
    write_reg(RegOriginY,      CfgDataW'(c.origin_y));
    write_reg(RegSourceWidth,  CfgDataW'(c.source_width));
    write_reg(RegBlendMode,    CfgDataW'(c.aura_mode));
    write_reg(RegMaskHigh,     CfgDataW'(c.mask_inside_high));
    write_reg(RegKeyColor,     CfgDataW'(c.key_color));
    cfg_we_i <= 1'b0;
  endtask

  // Waits on the clock before returning, so valid is never lowered and raised in one step.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (write_q.size() != 0);
  endtask

  task automatic feed_pixel(sprite_pixel_t px, bit typed, canvas_write_t want);
    canvas_write_t pred;
    int unsigned   gap;
    in_valid_i    <= 1'b1;
    frame_start_i <= px.frame_start;
    src_red_i     <= px.red;
    src_green_i   <= px.green;
    src_blue_i    <= px.blue;
    mask_covers_i <= px.mask_covers;
    mask_bit_i    <= px.mask_bit;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_write(px);
    write_q.push_back(typed ? want : pred);
    pixels_sent++;
    gap = src_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side: check each accepted write, then decide the next stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_w = '{write_enable_o, byte_address_o, out_red_o, out_green_o,
                  out_blue_o, out_alpha_o};
        if (write_q.size() == 0) begin
          flag_mismatch($sformatf("canvas write with no request pending, address 0x%0h",
                                  byte_address_o));
        end else begin
          want_w = write_q.pop_front();
          check_field("write_enable", got_w.write_enable, want_w.write_enable);
          check_field("byte_address", got_w.byte_address, want_w.byte_address);
          check_field("red",          got_w.red,          want_w.red);
          check_field("green",        got_w.green,        want_w.green);
          check_field("blue",         got_w.blue,         want_w.blue);
          check_field("alpha",        got_w.alpha,        want_w.alpha);
        end
        writes_checked++;
        if (got_w.write_enable) writes_enabled++;
      end
      if ($urandom_range(0, 199) == 0) snk_steady = !snk_steady;
      if (snk_hold != 0) begin
        snk_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!snk_steady && $urandom_range(0, 3) == 0) snk_hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no request moved for %0d cycles, %0d writes outstanding",
               $time, idle_cycles, write_q.size());
      $display("[sprite_stamp_blitter_top] ERROR");
      $finish;
    end
  end

  initial begin
    cfg_t rc;
    int   sprite_left;
    bit   fs;

    shadow  = '{CanvasWidthRst, CanvasHeightRst, '0, '0, SourceWidthRst,
                1'b0, 1'b1, KeyColorRst};
    col_pos = '0;
    row_pos = '0;

    // Directed part, starting from the reset register values.
    add_pix(pix(1, 24'h000000, 0, 0), 1, wr(1, 0, 24'h000000));
    add_pix(pix(0, 24'hFFFFFF, 0, 0), 1, wr(0, 2560, 24'hFFFFFF));
    add_pix(pix(0, 24'hFFFFFF, 1, 1), 1, wr(1, 5120, 24'hFFFFFF));
    add_pix(pix(0, 24'h123456, 1, 0), 1, wr(0, 7680, 24'h123456));
    add_reg(RegMaskHigh, 24'h0);
    add_reg(RegKeyColor, 24'h123456);
    add_pix(pix(0, 24'h000000, 1, 0));
    add_pix(pix(0, 24'h123456, 0, 0));
    add_pix(pix(0, 24'h123457, 0, 1));
    // sprite far off the left edge
    add_reg(RegOriginX, 24'h1000);
    add_reg(RegOriginY, 24'h0FFF);
    add_pix(pix(1, 24'hAA55AA, 0, 0), 1, wr(0, 0, 24'hAA55AA));
    // last canvas pixel of the largest canvas, then just past the right edge
    add_reg(RegCanvasWidth, 24'h1000);
    add_reg(RegCanvasHeight, 24'h1000);
    add_reg(RegOriginX, 24'h0FFF);
    add_reg(RegOriginY, 24'h0FFF);
    add_reg(RegSourceWidth, 24'h1000);
    add_pix(pix(1, 24'h000000, 0, 0), 1, wr(1, 67108860, 24'h000000));
    add_pix(pix(0, 24'h000000, 0, 0), 1, wr(0, 0, 24'h000000));
    // aura mode on a zero-width canvas: nothing lands
    add_reg(RegBlendMode, 24'h1);
    add_reg(RegCanvasWidth, 24'h0);
    add_reg(RegOriginX, 24'h0);
    add_reg(RegOriginY, 24'h0);
    add_pix(pix(1, 24'h7F7F7F, 0, 0), 1, wr(0, 0, 24'hFFFFFF));
    // oversized canvas, zero source width acting as one
    add_reg(RegCanvasWidth, 24'h1FFF);
    add_reg(RegCanvasHeight, 24'h1FFF);
    add_reg(RegSourceWidth, 24'h0);
    add_pix(pix(1, 24'h7F7F7F, 0, 0), 1, wr(1, 0, 24'hFFFFFF));
    add_pix(pix(0, 24'h800000, 0, 0));
    add_pix(pix(0, 24'h008000, 1, 1));
    add_pix(pix(0, 24'h000080, 0, 0));
    add_pix(pix(0, 24'h000000, 1, 0));
    // small canvas, sprite clipped left and bottom
    add_reg(RegBlendMode, 24'h0);
    add_reg(RegMaskHigh, 24'h1);
    add_reg(RegKeyColor, 24'h0);
    add_reg(RegCanvasWidth, 24'h3);
    add_reg(RegCanvasHeight, 24'h2);
    add_reg(RegOriginX, 24'h1FFF);
    add_reg(RegOriginY, 24'h0);
    add_reg(RegSourceWidth, 24'h3);
    add_pix(pix(1, 24'h000000, 0, 0));
    add_pix(pix(0, 24'h102030, 0, 0));
    add_pix(pix(0, 24'hFFFFFF, 0, 1));
    add_pix(pix(0, 24'h000000, 1, 1));
    add_pix(pix(0, 24'h0A0B0C, 0, 0));
    add_pix(pix(0, 24'h000000, 0, 0));
    add_pix(pix(0, 24'h808080, 1, 0));
    add_pix(pix(0, 24'h7F7F7F, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == RowReg) begin
        if (i == 0 || plan[i-1].kind != RowReg) drain();
        write_reg(plan[i].idx, plan[i].data);
        if (i + 1 == plan.size() || plan[i+1].kind != RowReg) cfg_we_i <= 1'b0;
      end else begin
        feed_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: mostly small canvases and sprites so the edges get hit often.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      rc.canvas_width     = rand_dim();
      rc.canvas_height    = rand_dim();
      rc.origin_x         = rand_origin();
      rc.origin_y         = rand_origin();
      case ($urandom_range(0, 9))
        0:       rc.source_width = '0;
        1:       rc.source_width = DimW'(MaxDim);
        2:       rc.source_width = '1;
        default: rc.source_width = DimW'($urandom_range(1, 8));
      endcase
      rc.aura_mode        = 1'($urandom);
      rc.mask_inside_high = 1'($urandom);
      case ($urandom_range(0, 3))
        0:       rc.key_color = '0;
        1:       rc.key_color = '1;
        default: rc.key_color = KeyW'($urandom);
      endcase
      program_regs(rc);
      src_steady  = ($urandom_range(0, 3) == 0);
      sprite_left = 0;
      repeat (PhasePixels) begin
        if (sprite_left == 0) begin
          sprite_left = $urandom_range(1, 40);
          fs = 1'b1;
        end else begin
          fs = ($urandom_range(0, 49) == 0);
        end
        sprite_left--;
        feed_pixel(rand_pixel(fs), 1'b0, '0);
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    // One tall sprite one pixel wide, starting a row above a narrow canvas.
    drain();
    rc = '{DimW'(3), '1, '0, '1, DimW'(1), 1'b0, 1'b1, KeyW'($urandom)};
    program_regs(rc);
    src_steady = 1'b0;
    for (int n = 0; n < TallPixels; n++) begin
      feed_pixel(rand_pixel(n == 0), 1'b0, '0);
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("%0d pixels through %0d register writes, clipped on every canvas edge",
             pixels_sent, reg_writes);
    $display("%0d canvas writes compared, %0d of them enabled, %0d mismatches",
             writes_checked, writes_enabled, mismatches);
    if (mismatches == 0) begin
      $display("[sprite_stamp_blitter_top] OK");
    end else begin
      $display("[sprite_stamp_blitter_top] ERROR");
    end
    $finish;
  end

endmodule
